@@ design/sia_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sia_pkg
// Shared sizes, operation and status codes, and controller/datapath structs
// for the shift-insert array engine.
// ----------------------------------------------------------------------------
package sia_pkg;

  localparam int CAPACITY  = 64;
  localparam int WORD_BITS = 32;

  // Port field widths
  localparam int OP_W   = 3;
  localparam int POS_W  = 6;
  localparam int DATA_W = 32;
  localparam int NLEN_W = 7;
  localparam int ST_W   = 2;

  // Storage widths
  localparam int WORD_W = WORD_BITS;
  localparam int IDX_W  = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int LEN_W  = $clog2(CAPACITY + 1);
  // Compare width wide enough for length, position and requested length
  localparam int CW     = (LEN_W > NLEN_W) ? LEN_W : NLEN_W;

  localparam logic [OP_W-1:0] OP_READ   = 3'd0;
  localparam logic [OP_W-1:0] OP_WRITE  = 3'd1;
  localparam logic [OP_W-1:0] OP_INSERT = 3'd2;
  localparam logic [OP_W-1:0] OP_APPEND = 3'd3;
  localparam logic [OP_W-1:0] OP_REMOVE = 3'd4;
  localparam logic [OP_W-1:0] OP_FIND   = 3'd5;
  localparam logic [OP_W-1:0] OP_RESIZE = 3'd6;
  localparam logic [OP_W-1:0] OP_ERASE  = 3'd7;

  localparam logic [ST_W-1:0] ST_OK         = 2'd0;
  localparam logic [ST_W-1:0] ST_BAD_RANGE  = 2'd1;
  localparam logic [ST_W-1:0] ST_BAD_LENGTH = 2'd2;
  localparam logic [ST_W-1:0] ST_FULL       = 2'd3;

  typedef enum logic [1:0] {
    WR_VAL,
    WR_Q,
    WR_ZERO
  } sia_wr_src_t;

  typedef struct packed {
    logic        load;
    logic        mem_rd;
    logic        mem_wr;
    sia_wr_src_t wr_src;
    logic        idx_init;
    logic        idx_step;
    logic        finish;
  } sia_cmd_t;

  typedef struct packed {
    logic [OP_W-1:0]  op;
    logic             fail;
    logic             loop_end;
    logic             match;
    logic [LEN_W-1:0] length;
  } sia_stat_t;

endpackage

@@ design/sia_req_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sia_req_if
// Request channel: valid/ready handshake with the operation fields.
// ----------------------------------------------------------------------------
interface sia_req_if;
  import sia_pkg::*;

  logic              valid;
  logic              ready;
  logic [OP_W-1:0]   operation;
  logic [POS_W-1:0]  position;
  logic [DATA_W-1:0] value;
  logic [NLEN_W-1:0] new_length;

  modport source (output valid, operation, position, value, new_length, input ready);
  modport sink   (input valid, operation, position, value, new_length, output ready);
endinterface

@@ design/sia_rsp_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sia_rsp_if
// Response channel: valid/ready handshake with the result fields.
// ----------------------------------------------------------------------------
interface sia_rsp_if;
  import sia_pkg::*;

  logic              valid;
  logic              ready;
  logic [DATA_W-1:0] read_data;
  logic              found;
  logic [POS_W-1:0]  found_position;
  logic [NLEN_W-1:0] current_length;
  logic [ST_W-1:0]   status;

  modport source (output valid, read_data, found, found_position, current_length, status,
                  input ready);
  modport sink   (input valid, read_data, found, found_position, current_length, status,
                  output ready);
endinterface

@@ design/sia_datapath.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sia_datapath
// Element memory, length register, walk index, range checks and the
// result register.
// ----------------------------------------------------------------------------
module sia_datapath (
  input  logic                     clk,
  input  logic                     rst,
  input  sia_pkg::sia_cmd_t        cmd,
  output sia_pkg::sia_stat_t       stat,
  input  logic [sia_pkg::OP_W-1:0]   in_operation,
  input  logic [sia_pkg::POS_W-1:0]  in_position,
  input  logic [sia_pkg::DATA_W-1:0] in_value,
  input  logic [sia_pkg::NLEN_W-1:0] in_new_length,
  output logic [sia_pkg::DATA_W-1:0] read_data,
  output logic                       found,
  output logic [sia_pkg::POS_W-1:0]  found_position,
  output logic [sia_pkg::NLEN_W-1:0] current_length,
  output logic [sia_pkg::ST_W-1:0]   status
);
  import sia_pkg::*;

  logic [WORD_W-1:0] mem [CAPACITY];

  logic [OP_W-1:0]   op_q;
  logic [POS_W-1:0]  pos_q;
  logic [WORD_W-1:0] val_q;
  logic [NLEN_W-1:0] nl_q;
  logic [LEN_W-1:0]  len;
  logic [LEN_W-1:0]  len_next;
  logic [LEN_W-1:0]  idx;
  logic [LEN_W-1:0]  idx_inc;
  logic [LEN_W-1:0]  idx_dec;
  logic [WORD_W-1:0] q;

  logic [CW-1:0]     pos_c, len_c, nl_c, idx_c;
  logic              range_bad, is_full, same_len;
  logic [ST_W-1:0]   chk_status;
  logic              fail;
  logic              loop_end;
  logic              match;
  logic [IDX_W-1:0]  rd_addr, wr_addr;
  logic [WORD_W-1:0] wr_data;
  logic              hit;

  assign pos_c   = CW'(pos_q);
  assign len_c   = CW'(len);
  assign nl_c    = CW'(nl_q);
  assign idx_c   = CW'(idx);
  assign idx_inc = idx + LEN_W'(1);
  assign idx_dec = idx - LEN_W'(1);

  assign range_bad = pos_c >= len_c;
  assign is_full   = len_c >= CW'(CAPACITY);
  assign same_len  = nl_c == len_c;
  assign match     = q == val_q;

  always_comb begin
    unique case (op_q)
      OP_READ, OP_WRITE, OP_REMOVE: chk_status = range_bad ? ST_BAD_RANGE : ST_OK;
      OP_INSERT: chk_status = range_bad ? ST_BAD_RANGE : (is_full ? ST_FULL : ST_OK);
      OP_APPEND: chk_status = is_full ? ST_FULL : ST_OK;
      OP_RESIZE: begin
        if (same_len) begin
          chk_status = ST_OK;
        end else if (nl_c == CW'(0) || nl_c > CW'(CAPACITY)) begin
          chk_status = ST_BAD_LENGTH;
        end else begin
          chk_status = ST_OK;
        end
      end
      default: chk_status = ST_OK;
    endcase
  end

  // Resize to the current length succeeds but changes nothing
  assign fail = (chk_status != ST_OK) || (op_q == OP_RESIZE && same_len);

  always_comb begin
    unique case (op_q)
      OP_INSERT: loop_end = idx_c == pos_c;
      OP_REMOVE: loop_end = (idx_c + CW'(1)) >= len_c;
      OP_FIND:   loop_end = idx_c == len_c;
      OP_RESIZE: loop_end = idx_c >= nl_c;
      default:   loop_end = 1'b1;
    endcase
  end

  always_comb begin
    unique case (op_q)
      OP_READ:   rd_addr = IDX_W'(pos_q);
      OP_INSERT: rd_addr = IDX_W'(idx_dec);
      OP_REMOVE: rd_addr = IDX_W'(idx_inc);
      default:   rd_addr = IDX_W'(idx);
    endcase
  end

  always_comb begin
    unique case (op_q)
      OP_WRITE:  wr_addr = IDX_W'(pos_q);
      OP_APPEND: wr_addr = IDX_W'(len);
      default:   wr_addr = IDX_W'(idx);
    endcase
  end

  always_comb begin
    unique case (cmd.wr_src)
      WR_VAL:  wr_data = val_q;
      WR_Q:    wr_data = q;
      default: wr_data = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.mem_wr) begin
      mem[wr_addr] <= wr_data;
    end
    if (cmd.mem_rd) begin
      q <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_q  <= in_operation;
      pos_q <= in_position;
      val_q <= WORD_W'($signed(in_value));
      nl_q  <= in_new_length;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.idx_init) begin
      unique case (op_q)
        OP_REMOVE: idx <= LEN_W'(pos_q);
        OP_FIND:   idx <= '0;
        default:   idx <= len;
      endcase
    end else if (cmd.idx_step) begin
      idx <= (op_q == OP_INSERT) ? idx_dec : idx_inc;
    end
  end

  always_comb begin
    len_next = len;
    if (!fail) begin
      unique case (op_q)
        OP_INSERT, OP_APPEND: len_next = len + LEN_W'(1);
        OP_REMOVE:            len_next = len - LEN_W'(1);
        OP_RESIZE:            len_next = LEN_W'(nl_q);
        OP_ERASE:             len_next = '0;
        default:              len_next = len;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      len <= '0;
    end else if (cmd.finish) begin
      len <= len_next;
    end
  end

  // A find that stopped before the end stopped on a match
  assign hit = (op_q == OP_FIND) && match && !loop_end;

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      read_data      <= (op_q == OP_READ && !fail) ? DATA_W'($signed(q)) : '0;
      found          <= hit;
      found_position <= hit ? POS_W'(idx) : '0;
      current_length <= NLEN_W'(len_next);
      status         <= chk_status;
    end
  end

  assign stat.op       = op_q;
  assign stat.fail     = fail;
  assign stat.loop_end = loop_end;
  assign stat.match    = match;
  assign stat.length   = len;

endmodule

@@ design/sia_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sia_ctrl
// Sequencer: decodes the operation, walks the element memory one read and
// one write per moved element, and hands the result to the output register.
// ----------------------------------------------------------------------------
module sia_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  output logic                out_valid,
  input  logic                out_ready,
  input  sia_pkg::sia_stat_t  stat,
  output sia_pkg::sia_cmd_t   cmd
);
  import sia_pkg::*;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_DECODE = 3'd1;
  localparam logic [2:0] S_CHECK  = 3'd2;
  localparam logic [2:0] S_MOVE   = 3'd3;
  localparam logic [2:0] S_FIN    = 3'd4;

  logic [2:0] state, state_next;
  logic       out_free;

  assign in_ready = (state == S_IDLE);
  assign out_free = !out_valid || out_ready;

  always_comb begin
    state_next   = state;
    cmd          = '0;
    cmd.wr_src   = WR_VAL;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_DECODE;
        end
      end
      S_DECODE: begin
        if (stat.fail) begin
          state_next = S_FIN;
        end else begin
          unique case (stat.op)
            OP_READ: begin
              cmd.mem_rd = 1'b1;
              state_next = S_FIN;
            end
            OP_WRITE, OP_APPEND: begin
              cmd.mem_wr = 1'b1;
              state_next = S_FIN;
            end
            OP_ERASE: state_next = S_FIN;
            OP_INSERT, OP_REMOVE, OP_FIND, OP_RESIZE: begin
              cmd.idx_init = 1'b1;
              state_next   = S_CHECK;
            end
          endcase
        end
      end
      S_CHECK: begin
        if (stat.loop_end) begin
          // insert lands the new word once the gap reaches its position
          cmd.mem_wr = (stat.op == OP_INSERT);
          state_next = S_FIN;
        end else if (stat.op == OP_RESIZE) begin
          cmd.mem_wr   = 1'b1;
          cmd.wr_src   = WR_ZERO;
          cmd.idx_step = 1'b1;
        end else begin
          cmd.mem_rd = 1'b1;
          state_next = S_MOVE;
        end
      end
      S_MOVE: begin
        if (stat.op == OP_FIND) begin
          if (stat.match) begin
            state_next = S_FIN;
          end else begin
            cmd.idx_step = 1'b1;
            state_next   = S_CHECK;
          end
        end else begin
          cmd.mem_wr   = 1'b1;
          cmd.wr_src   = WR_Q;
          cmd.idx_step = 1'b1;
          state_next   = S_CHECK;
        end
      end
      S_FIN: begin
        if (out_free) begin
          cmd.finish = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.finish) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

@@ design/shift_insert_array_engine_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// shift_insert_array_engine_top
// Ordered array of signed words with read, write, insert, append, remove,
// find, resize and erase; one response per request.
// ----------------------------------------------------------------------------
//  channel  dir  payload
//  cmd      in   operation, position, value, new_length
//  rsp      out  read_data, found, found_position, current_length, status
//
// Read, write, append, erase and any rejected request go from decode
// straight to the final state; shrink, insert, remove, find and growing
// resize first walk the element memory. Each moved element is read in
// S_CHECK and written in S_MOVE; a growing resize writes zeros from
// S_CHECK alone, and a find stops in S_MOVE on a hit.
// Reset clears the length and the sequencer; memory contents are not cleared.
// One request in flight; a response waiting on rsp.ready holds the sequencer
// in its final state, and cmd.ready returns once the response is loaded.
// ----------------------------------------------------------------------------
module shift_insert_array_engine_top (
  input  logic      clk,
  input  logic      rst,
  sia_req_if.sink   cmd,
  sia_rsp_if.source rsp
);
  import sia_pkg::*;

  sia_cmd_t  dp_cmd;
  sia_stat_t dp_stat;

  sia_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (cmd.valid),
    .in_ready  (cmd.ready),
    .out_valid (rsp.valid),
    .out_ready (rsp.ready),
    .stat      (dp_stat),
    .cmd       (dp_cmd)
  );

  sia_datapath u_dp (
    .clk            (clk),
    .rst            (rst),
    .cmd            (dp_cmd),
    .stat           (dp_stat),
    .in_operation   (cmd.operation),
    .in_position    (cmd.position),
    .in_value       (cmd.value),
    .in_new_length  (cmd.new_length),
    .read_data      (rsp.read_data),
    .found          (rsp.found),
    .found_position (rsp.found_position),
    .current_length (rsp.current_length),
    .status         (rsp.status)
  );

  a_len_bound: assert property (@(posedge clk) disable iff (rst)
    dp_stat.length <= LEN_W'(CAPACITY))
    else $error("length exceeds capacity");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (cmd.valid && cmd.ready) |=> !cmd.ready)
    else $error("request accepted while busy");

  a_found_in_range: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && rsp.found) |->
      (rsp.status == ST_OK && NLEN_W'(rsp.found_position) < rsp.current_length))
    else $error("found position outside array");

endmodule

@@ tb/sv/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for shift_insert_array_engine_top. A driver sends
// directed then random array operations from a queue. A monitor keeps a
// shadow copy of the array, predicts each response at the command transaction,
// and compares every response transaction field by field. Sender gaps and
// receiver stalls change from phase to phase.
// ----------------------------------------------------------------------------
module tb;
  import sia_pkg::*;

  localparam int WATCHDOG_LIMIT = 4000;  // covers the longest find walk, plus stalls
  localparam int DRAIN_CYCLES   = 150;
  localparam int RANDOM_ITEMS   = 400;
  localparam int PHASE_ITEMS    = 50;

  typedef struct packed {
    logic [OP_W-1:0]   operation;
    logic [POS_W-1:0]  position;
    logic [DATA_W-1:0] value;
    logic [NLEN_W-1:0] new_length;
  } array_cmd_t;

  typedef struct packed {
    logic [DATA_W-1:0] read_data;
    logic              found;
    logic [POS_W-1:0]  found_position;
    logic [NLEN_W-1:0] current_length;
    logic [ST_W-1:0]   status;
  } array_rsp_t;

  logic clk;
  logic rst;

  sia_req_if cmd_if();
  sia_rsp_if rsp_if();

  shift_insert_array_engine_top i_dut (
    .clk (clk),
    .rst (rst),
    .cmd (cmd_if),
    .rsp (rsp_if)
  );

  array_cmd_t cmd_pending[$];
  array_rsp_t rsp_expected[$];

  // shadow of the array contents, updated at each command transaction
  logic [WORD_W-1:0] shadow_words[CAPACITY];
  int                shadow_len;

  int  gen_len;  // element count as the stimulus generator sees it
  int  item_total;
  int  cmds_accepted;
  int  rsps_checked;
  int  mismatches;
  int  idle_cycles;
  bit  cmd_taken;

  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  // 0: no idling, 1: sender gaps, 2: receiver stalls, 3: light idling on both
  function automatic int idle_phase();
    return (cmds_accepted / PHASE_ITEMS) % 4;
  endfunction

  function automatic bit sender_gap();
    case (idle_phase())
      1: return $urandom_range(0, 99) < 86;
      3: return $urandom_range(0, 99) < 19;
      default: return 1'b0;
    endcase
  endfunction

  function automatic bit receiver_stall();
    case (idle_phase())
      2: return $urandom_range(0, 99) < 86;
      3: return $urandom_range(0, 99) < 19;
      default: return 1'b0;
    endcase
  endfunction

  function automatic array_rsp_t apply_array_op(array_cmd_t c);
    array_rsp_t r;
    int         i;
    r = '0;
    case (c.operation)
      OP_READ: begin
        if (c.position >= shadow_len) r.status = ST_BAD_RANGE;
        else r.read_data = shadow_words[c.position];
      end
      OP_WRITE: begin
        if (c.position >= shadow_len) r.status = ST_BAD_RANGE;
        else shadow_words[c.position] = c.value;
      end
      OP_INSERT: begin
        if (c.position >= shadow_len) begin
          r.status = ST_BAD_RANGE;
        end else if (shadow_len >= CAPACITY) begin
          r.status = ST_FULL;
        end else begin
          for (i = shadow_len; i > c.position; i--) shadow_words[i] = shadow_words[i-1];
          shadow_words[c.position] = c.value;
          shadow_len++;
        end
      end
      OP_APPEND: begin
        if (shadow_len >= CAPACITY) begin
          r.status = ST_FULL;
        end else begin
          shadow_words[shadow_len] = c.value;
          shadow_len++;
        end
      end
      OP_REMOVE: begin
        if (c.position >= shadow_len) begin
          r.status = ST_BAD_RANGE;
        end else begin
          for (i = c.position; i + 1 < shadow_len; i++) shadow_words[i] = shadow_words[i+1];
          shadow_len--;
        end
      end
      OP_FIND: begin
        for (i = 0; i < shadow_len; i++) begin
          if (shadow_words[i] == c.value) begin
            r.found          = 1'b1;
            r.found_position = POS_W'(i);
            break;
          end
        end
      end
      OP_RESIZE: begin
        if (c.new_length == shadow_len) begin
          // same length: nothing to do
        end else if (c.new_length == 0 || c.new_length > CAPACITY) begin
          r.status = ST_BAD_LENGTH;
        end else begin
          for (i = shadow_len; i < c.new_length; i++) shadow_words[i] = '0;
          shadow_len = int'(c.new_length);
        end
      end
      OP_ERASE: shadow_len = 0;
    endcase
    r.current_length = NLEN_W'(shadow_len);
    return r;
  endfunction

  // generator side only needs the element count to aim positions
  function automatic void add_item(logic [OP_W-1:0] op, int pos, logic [DATA_W-1:0] val,
                                   int nlen);
    array_cmd_t c;
    c.operation  = op;
    c.position   = POS_W'(pos);
    c.value      = val;
    c.new_length = NLEN_W'(nlen);
    cmd_pending.push_back(c);
    case (op)
      OP_INSERT: if (pos < gen_len && gen_len < CAPACITY) gen_len++;
      OP_APPEND: if (gen_len < CAPACITY) gen_len++;
      OP_REMOVE: if (pos < gen_len) gen_len--;
      OP_RESIZE: if (nlen != 0 && nlen <= CAPACITY) gen_len = nlen;
      OP_ERASE:  gen_len = 0;
      default: ;
    endcase
  endfunction

  // small values repeat often so that find hits
  function automatic logic [DATA_W-1:0] pick_value();
    case ($urandom_range(0, 3))
      0, 1: return $urandom_range(0, 7) - 4;
      2: return $urandom();
      default: return $urandom_range(0, 1) ? 32'h8000_0000 : 32'h7FFF_FFFF;
    endcase
  endfunction

  function automatic int pick_position();
    if (gen_len > 0 && $urandom_range(0, 99) < 80) return $urandom_range(0, gen_len - 1);
    return $urandom_range(0, 63);
  endfunction

  function automatic int pick_new_length();
    case ($urandom_range(0, 19))
      0: return 0;
      1: return $urandom_range(CAPACITY + 1, 127);
      2: return gen_len;
      3: return CAPACITY;
      default: return $urandom_range(1, 16);
    endcase
  endfunction

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $display("%0t ns: %s mismatch: expected 0x%0h, actual 0x%0h", $time, name, want, got);
      mismatches++;
    end
  endtask

  // driver: hold the current transaction until taken, then maybe idle
  always @(negedge clk) begin
    array_cmd_t nxt;
    if (rst) begin
      cmd_if.valid <= 1'b0;
    end else if (!(cmd_if.valid && !cmd_taken)) begin
      if (cmd_pending.size() != 0 && !sender_gap()) begin
        nxt = cmd_pending.pop_front();
        cmd_if.valid      <= 1'b1;
        cmd_if.operation  <= nxt.operation;
        cmd_if.position   <= nxt.position;
        cmd_if.value      <= nxt.value;
        cmd_if.new_length <= nxt.new_length;
      end else begin
        cmd_if.valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    rsp_if.ready <= !rst && !receiver_stall();
  end

  // monitor: predict on command transactions, compare response transactions
  always @(posedge clk) begin
    array_cmd_t c;
    array_rsp_t want;
    if (rst) begin
      cmd_taken = 1'b0;
    end else begin
      cmd_taken = cmd_if.valid && cmd_if.ready;
      if (cmd_taken) begin
        c.operation  = cmd_if.operation;
        c.position   = cmd_if.position;
        c.value      = cmd_if.value;
        c.new_length = cmd_if.new_length;
        rsp_expected.push_back(apply_array_op(c));
        cmds_accepted++;
      end
      if (rsp_if.valid && rsp_if.ready) begin
        if (rsp_expected.size() == 0) begin
          $display("%0t ns: unexpected response: expected none, actual length %0d status %0d",
                   $time, rsp_if.current_length, rsp_if.status);
          mismatches++;
        end else begin
          want = rsp_expected.pop_front();
          check_field("read_data", want.read_data, rsp_if.read_data);
          check_field("found", want.found, rsp_if.found);
          check_field("found_position", want.found_position, rsp_if.found_position);
          check_field("current_length", want.current_length, rsp_if.current_length);
          check_field("status", want.status, rsp_if.status);
          rsps_checked++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (cmd_if.valid && cmd_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t ns: no transaction for %0d cycles", $time, idle_cycles);
        $display("shift_insert_array_engine_top verification failed");
        $finish;
      end
    end
  end

  initial begin
    int              r;
    logic [OP_W-1:0] op;
    rst               = 1'b1;
    cmd_if.valid      = 1'b0;
    cmd_if.operation  = OP_READ;
    cmd_if.position   = '0;
    cmd_if.value      = '0;
    cmd_if.new_length = '0;
    rsp_if.ready      = 1'b0;
    shadow_len        = 0;
    gen_len           = 0;
    cmds_accepted     = 0;
    rsps_checked      = 0;
    mismatches        = 0;
    idle_cycles       = 0;
    cmd_taken         = 1'b0;
    foreach (shadow_words[i]) shadow_words[i] = '0;

    // directed: empty array, bad lengths, word extremes, shifts, full array
    add_item(OP_READ,   0, '0, 0);
    add_item(OP_WRITE,  0, 32'h1234_5678, 0);
    add_item(OP_INSERT, 0, 32'h1111_1111, 0);
    add_item(OP_REMOVE, 0, '0, 0);
    add_item(OP_FIND,   0, '0, 0);
    add_item(OP_RESIZE, 0, '0, 0);
    add_item(OP_ERASE,  0, '0, 0);
    add_item(OP_RESIZE, 0, '0, CAPACITY + 1);
    add_item(OP_APPEND, 0, 32'h7FFF_FFFF, 0);
    add_item(OP_RESIZE, 0, '0, 0);
    add_item(OP_APPEND, 0, 32'h8000_0000, 0);
    add_item(OP_INSERT, 0, 32'hFFFF_FFFF, 0);
    add_item(OP_INSERT, 2, 32'h0000_0000, 0);
    add_item(OP_READ,   3, '0, 0);
    add_item(OP_READ,   4, '0, 0);
    add_item(OP_FIND,   0, 32'h8000_0000, 0);
    add_item(OP_FIND,   0, 32'd12345, 0);
    add_item(OP_WRITE,  1, 32'h55AA_55AA, 0);
    add_item(OP_REMOVE, 3, '0, 0);
    add_item(OP_REMOVE, 0, '0, 0);
    add_item(OP_RESIZE, 63, 32'hFFFF_FFFF, CAPACITY);
    add_item(OP_INSERT, 63, 32'hAAAA_AAAA, 0);
    add_item(OP_APPEND, 0, 32'h5555_5555, 0);
    add_item(OP_FIND,   0, '0, 0);
    add_item(OP_READ,   63, '0, 0);
    add_item(OP_RESIZE, 0, '0, 1);
    add_item(OP_ERASE,  0, '0, 0);
    add_item(OP_RESIZE, 0, '0, 127);

    repeat (RANDOM_ITEMS) begin
      r = $urandom_range(0, 99);
      if (r < 15) op = OP_READ;
      else if (r < 27) op = OP_WRITE;
      else if (r < 42) op = OP_INSERT;
      else if (r < 57) op = OP_APPEND;
      else if (r < 73) op = OP_REMOVE;
      else if (r < 88) op = OP_FIND;
      else if (r < 96) op = OP_RESIZE;
      else op = OP_ERASE;
      add_item(op, pick_position(), pick_value(), pick_new_length());
    end
    item_total = cmd_pending.size();

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    while (cmds_accepted != item_total || rsp_expected.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);

    if (mismatches == 0) begin
      $display("shift_insert_array_engine_top verification clean");
    end else begin
      $display("shift_insert_array_engine_top verification failed");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
design/sia_pkg.sv
design/sia_req_if.sv
design/sia_rsp_if.sv
design/sia_datapath.sv
design/sia_ctrl.sv
design/shift_insert_array_engine_top.sv
tb/sv/tb.sv
